FILE: rtl/core/string_key_hash_table_core_assert.svh
// Assertion macros used by the checker file sktab_checker.sv.
`ifndef STRING_KEY_HASH_TABLE_CORE_ASSERT_SVH
`define STRING_KEY_HASH_TABLE_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SKTAB_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sktab assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define SKTAB_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sktab assertion failed");

`endif

FILE: rtl/core/sktab_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sktab_pkg;

    localparam int DEF_MAX_BUCKETS = 256;
    localparam int DEF_MAX_ENTRIES = 1024;
    localparam int DEF_MAX_KEY_LEN = 32;

    localparam logic [63:0] HASH_SEED = 64'd5381;
    localparam logic [8:0]  BUCKET_COUNT_RST = 9'd256;

    // result status codes
    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_FOUND     = 3'd1;
    localparam logic [2:0] ST_MISSING   = 3'd2;
    localparam logic [2:0] ST_POOL_FULL = 3'd3;
    localparam logic [2:0] ST_TOO_LONG  = 3'd4;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    // finished key handed from front to back
    typedef struct packed {
        logic [63:0] hash;
        logic        command;
        logic        overlong;
        logic [15:0] index_value;
    } job_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_MOD,
        B_HEAD,
        B_HEAD_W,
        B_INS_KEY,
        B_INS_META,
        B_META,
        B_META_W,
        B_KEY_RD,
        B_KEY_W,
        B_DONE
    } back_state_t;

endpackage
`default_nettype wire

FILE: rtl/core/sktab_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module sktab_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic                                  clk,
    input  wire logic                                  we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write one word, read one word registered
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

FILE: rtl/core/sktab_front.sv
`timescale 1ns / 1ps
`default_nettype none
module sktab_front #(
    parameter int MAX_KEY_LEN = 32,
    parameter int LEN_W       = 6,
    parameter int KI_W        = 5
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic              command,
    input  wire logic [7:0]        key_char,
    input  wire logic              key_last,
    input  wire logic [15:0]       index_value,
    input  wire logic              back_busy,
    input  wire logic              job_take,
    output logic                   job_valid,
    output sktab_pkg::job_t        job,
    output logic [LEN_W-1:0]       job_len,
    input  wire logic [KI_W-1:0]   kb_idx,
    output logic [7:0]             kb_char
);
    import sktab_pkg::*;

    logic [63:0]      hash_reg, hash_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic             ovl_reg, ovl_next;
    logic             job_valid_reg, job_valid_next;
    job_t             job_reg, job_next;
    logic [LEN_W-1:0] job_len_reg, job_len_next;
    logic [7:0]       keybuf [MAX_KEY_LEN];
    logic             accept;
    logic             buf_we;

    assign busy    = job_valid_reg | back_busy;
    assign accept  = start & ~busy;
    assign job_valid = job_valid_reg;
    assign job     = job_reg;
    assign job_len = job_len_reg;
    assign kb_char = keybuf[kb_idx];

    // fold a nonzero character into the hash and key, hand over at key end
    always_comb
    begin
        hash_next      = hash_reg;
        len_next       = len_reg;
        ovl_next       = ovl_reg;
        job_valid_next = job_valid_reg & ~job_take;
        job_next       = job_reg;
        job_len_next   = job_len_reg;
        buf_we         = 1'b0;
        if (accept)
        begin
            if (key_char != 8'd0)
            begin
                if (len_reg < LEN_W'(MAX_KEY_LEN))
                begin
                    buf_we   = 1'b1;
                    len_next = len_reg + LEN_W'(1);
                end
                else
                begin
                    ovl_next = 1'b1;
                end
                hash_next = (hash_reg << 5) + hash_reg + {56'd0, key_char};
            end
            if (key_last)
            begin
                job_valid_next       = 1'b1;
                job_next.hash        = hash_next;
                job_next.command     = command;
                job_next.overlong    = ovl_next;
                job_next.index_value = index_value;
                job_len_next         = len_next;
                hash_next            = HASH_SEED;
                len_next             = '0;
                ovl_next             = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg      <= HASH_SEED;
            len_reg       <= '0;
            ovl_reg       <= 1'b0;
            job_valid_reg <= 1'b0;
        end
        else
        begin
            hash_reg      <= hash_next;
            len_reg       <= len_next;
            ovl_reg       <= ovl_next;
            job_valid_reg <= job_valid_next;
        end
    end

    // hold job payload and key characters
    always_ff @(posedge clk)
    begin
        job_reg     <= job_next;
        job_len_reg <= job_len_next;
        if (buf_we)
        begin
            keybuf[len_reg[KI_W-1:0]] <= key_char;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/sktab_back.sv
`timescale 1ns / 1ps
`default_nettype none
module sktab_back #(
    parameter int MAX_BUCKETS = 256,
    parameter int MAX_ENTRIES = 1024,
    parameter int LEN_W       = 6,
    parameter int KI_W        = 5,
    parameter int BKT_W       = 8,
    parameter int EI_W        = 10,
    parameter int PTR_W       = 11
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [8:0]        bucket_count,
    input  wire logic              job_valid,
    input  wire sktab_pkg::job_t   job,
    input  wire logic [LEN_W-1:0]  job_len,
    output logic                   job_take,
    output logic                   back_busy,
    output logic [KI_W-1:0]        kb_idx,
    input  wire logic [7:0]        kb_char,
    output logic                   result_valid,
    output logic [2:0]             status,
    output logic [15:0]            found_index
);
    import sktab_pkg::*;

    localparam int META_W = LEN_W + 16 + PTR_W;
    localparam logic [PTR_W-1:0] LINK_NONE = PTR_W'(MAX_ENTRIES);

    back_state_t      state_reg, state_next;
    job_t             job_reg, job_r_next;
    logic [LEN_W-1:0] len_reg, len_r_next;
    logic [63:0]      hsh_reg, hsh_next;
    logic [8:0]       rem_reg, rem_next;
    logic [3:0]       cnt_reg, cnt_next;
    logic [BKT_W-1:0] bkt_reg, bkt_next;
    logic [PTR_W-1:0] ent_reg, ent_next;
    logic [LEN_W-1:0] ci_reg, ci_next;
    logic [PTR_W-1:0] mnext_reg, mnext_next;
    logic [15:0]      midx_reg, midx_next;
    logic [PTR_W-1:0] used_reg, used_next;
    logic [MAX_BUCKETS-1:0] hvalid_reg, hvalid_next;
    logic             rv_reg, rv_next;
    logic [2:0]       st_reg, st_next;
    logic [15:0]      fi_reg, fi_next;

    logic [8:0]       n_eff;
    logic [8:0]       rem_step;
    logic [9:0]       trial;

    logic                   head_we;
    logic [BKT_W-1:0]       head_raddr;
    logic [PTR_W-1:0]       head_rdata;
    logic                   meta_we;
    logic [EI_W-1:0]        meta_raddr;
    logic [META_W-1:0]      meta_wdata, meta_rdata;
    logic                   key_we;
    logic [EI_W+KI_W-1:0]   key_waddr, key_raddr;
    logic [7:0]             key_rdata;
    logic [LEN_W-1:0]       m_len;
    logic [15:0]            m_idx;
    logic [PTR_W-1:0]       m_next;

    assign back_busy    = (state_reg != B_IDLE);
    assign result_valid = rv_reg;
    assign status       = st_reg;
    assign found_index  = fi_reg;
    assign kb_idx       = ci_reg[KI_W-1:0];
    assign {m_len, m_idx, m_next} = meta_rdata;

    // clamp the bucket count into range
    always_comb
    begin
        if (bucket_count == 9'd0)
        begin
            n_eff = 9'd1;
        end
        else if (32'(bucket_count) > MAX_BUCKETS)
        begin
            n_eff = 9'(MAX_BUCKETS);
        end
        else
        begin
            n_eff = bucket_count;
        end
    end

    // four restoring remainder steps per cycle
    always_comb
    begin
        rem_step = rem_reg;
        trial    = '0;
        for (int k = 0; k < 4; k++)
        begin
            trial = {rem_step, hsh_reg[63-k]};
            if (trial >= {1'b0, n_eff})
            begin
                trial = trial - {1'b0, n_eff};
            end
            rem_step = trial[8:0];
        end
    end

    // sequencer for insert and chain walk
    always_comb
    begin
        state_next  = state_reg;
        job_r_next  = job_reg;
        len_r_next  = len_reg;
        hsh_next    = hsh_reg;
        rem_next    = rem_reg;
        cnt_next    = cnt_reg;
        bkt_next    = bkt_reg;
        ent_next    = ent_reg;
        ci_next     = ci_reg;
        mnext_next  = mnext_reg;
        midx_next   = midx_reg;
        used_next   = used_reg;
        hvalid_next = hvalid_reg;
        rv_next     = 1'b0;
        st_next     = st_reg;
        fi_next     = fi_reg;
        job_take    = 1'b0;
        head_we     = 1'b0;
        head_raddr  = bkt_reg;
        meta_we     = 1'b0;
        meta_raddr  = ent_reg[EI_W-1:0];
        meta_wdata  = {len_reg, job_reg.index_value, ent_reg};
        key_we      = 1'b0;
        key_waddr   = {used_reg[EI_W-1:0], ci_reg[KI_W-1:0]};
        key_raddr   = {ent_reg[EI_W-1:0], ci_reg[KI_W-1:0]};
        unique case (state_reg)
            B_IDLE:
            begin
                if (job_valid)
                begin
                    job_take   = 1'b1;
                    job_r_next = job;
                    len_r_next = job_len;
                    hsh_next   = job.hash;
                    rem_next   = '0;
                    cnt_next   = '0;
                    fi_next    = '0;
                    if (job.overlong)
                    begin
                        st_next    = ST_TOO_LONG;
                        state_next = B_DONE;
                    end
                    else if (job.command == CMD_INSERT && used_reg == LINK_NONE)
                    begin
                        st_next    = ST_POOL_FULL;
                        state_next = B_DONE;
                    end
                    else
                    begin
                        state_next = B_MOD;
                    end
                end
            end
            B_MOD:
            begin
                rem_next = rem_step;
                hsh_next = hsh_reg << 4;
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd15)
                begin
                    bkt_next   = BKT_W'(rem_step);
                    state_next = B_HEAD;
                end
            end
            B_HEAD:
            begin
                state_next = B_HEAD_W;
            end
            B_HEAD_W:
            begin
                ent_next = hvalid_reg[bkt_reg] ? head_rdata : LINK_NONE;
                ci_next  = '0;
                if (job_reg.command == CMD_INSERT)
                begin
                    state_next = B_INS_KEY;
                end
                else
                begin
                    state_next = B_META;
                end
            end
            B_INS_KEY:
            begin
                if (ci_reg == len_reg)
                begin
                    state_next = B_INS_META;
                end
                else
                begin
                    key_we  = 1'b1;
                    ci_next = ci_reg + LEN_W'(1);
                end
            end
            B_INS_META:
            begin
                meta_we              = 1'b1;
                head_we              = 1'b1;
                hvalid_next[bkt_reg] = 1'b1;
                used_next            = used_reg + PTR_W'(1);
                st_next              = ST_INSERTED;
                state_next           = B_DONE;
            end
            B_META:
            begin
                if (ent_reg == LINK_NONE)
                begin
                    st_next    = ST_MISSING;
                    state_next = B_DONE;
                end
                else
                begin
                    state_next = B_META_W;
                end
            end
            B_META_W:
            begin
                mnext_next = m_next;
                midx_next  = m_idx;
                ci_next    = '0;
                if (m_len != len_reg)
                begin
                    ent_next   = m_next;
                    state_next = B_META;
                end
                else if (len_reg == '0)
                begin
                    st_next    = ST_FOUND;
                    fi_next    = m_idx;
                    state_next = B_DONE;
                end
                else
                begin
                    state_next = B_KEY_RD;
                end
            end
            B_KEY_RD:
            begin
                state_next = B_KEY_W;
            end
            B_KEY_W:
            begin
                if (key_rdata != kb_char)
                begin
                    ent_next   = mnext_reg;
                    state_next = B_META;
                end
                else if ((ci_reg + LEN_W'(1)) == len_reg)
                begin
                    st_next    = ST_FOUND;
                    fi_next    = midx_reg;
                    state_next = B_DONE;
                end
                else
                begin
                    ci_next    = ci_reg + LEN_W'(1);
                    state_next = B_KEY_RD;
                end
            end
            B_DONE:
            begin
                rv_next    = 1'b1;
                state_next = B_IDLE;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_IDLE;
            used_reg   <= '0;
            hvalid_reg <= '0;
            rv_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            used_reg   <= used_next;
            hvalid_reg <= hvalid_next;
            rv_reg     <= rv_next;
        end
    end

    // hold working payload
    always_ff @(posedge clk)
    begin
        job_reg   <= job_r_next;
        len_reg   <= len_r_next;
        hsh_reg   <= hsh_next;
        rem_reg   <= rem_next;
        cnt_reg   <= cnt_next;
        bkt_reg   <= bkt_next;
        ent_reg   <= ent_next;
        ci_reg    <= ci_next;
        mnext_reg <= mnext_next;
        midx_reg  <= midx_next;
        st_reg    <= st_next;
        fi_reg    <= fi_next;
    end

    sktab_ram #(.WIDTH(PTR_W), .DEPTH(2 ** BKT_W)) u_heads (
        .clk   (clk),
        .we    (head_we),
        .waddr (bkt_reg),
        .wdata (used_reg),
        .raddr (head_raddr),
        .rdata (head_rdata)
    );

    sktab_ram #(.WIDTH(META_W), .DEPTH(2 ** EI_W)) u_meta (
        .clk   (clk),
        .we    (meta_we),
        .waddr (used_reg[EI_W-1:0]),
        .wdata (meta_wdata),
        .raddr (meta_raddr),
        .rdata (meta_rdata)
    );

    sktab_ram #(.WIDTH(8), .DEPTH(2 ** (EI_W + KI_W))) u_keys (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (kb_char),
        .raddr (key_raddr),
        .rdata (key_rdata)
    );

endmodule
`default_nettype wire

FILE: rtl/core/string_key_hash_table_core.sv
// Non-final characters are folded in without raising busy.
// A key end computes the bucket remainder (4 hash bits per cycle), reads the head,
// then on insert writes the key characters and metadata, or on search walks the
// chain comparing length and characters; result_valid then pulses once.
// Overlong keys and a full pool skip these steps; the receiver cannot stall.
// Reset (rst_n low, asynchronous) empties the table and sets bucket_count to 256.
`timescale 1ns / 1ps
`default_nettype none
module string_key_hash_table_core #(
    parameter int MAX_BUCKETS = sktab_pkg::DEF_MAX_BUCKETS,
    parameter int MAX_ENTRIES = sktab_pkg::DEF_MAX_ENTRIES,
    parameter int MAX_KEY_LEN = sktab_pkg::DEF_MAX_KEY_LEN
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        command,
    input  wire logic [7:0]  key_char,
    input  wire logic        key_last,
    input  wire logic [15:0] index_value,
    output logic             result_valid,
    output logic [2:0]       status,
    output logic [15:0]      found_index,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [8:0]  cfg_data
);
    import sktab_pkg::*;

    localparam int LEN_W = $clog2(MAX_KEY_LEN + 1);
    localparam int KI_W  = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;
    localparam int BKT_W = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int EI_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int PTR_W = $clog2(MAX_ENTRIES + 1);

    logic [8:0]       bucket_count_reg;
    logic             back_busy;
    logic             job_take;
    logic             job_valid;
    job_t             job;
    logic [LEN_W-1:0] job_len;
    logic [KI_W-1:0]  kb_idx;
    logic [7:0]       kb_char;

    assign cfg_ready = 1'b1;

    // take a configuration beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bucket_count_reg <= BUCKET_COUNT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            bucket_count_reg <= cfg_data;
        end
    end

    sktab_front #(.MAX_KEY_LEN(MAX_KEY_LEN), .LEN_W(LEN_W), .KI_W(KI_W)) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .command     (command),
        .key_char    (key_char),
        .key_last    (key_last),
        .index_value (index_value),
        .back_busy   (back_busy),
        .job_take    (job_take),
        .job_valid   (job_valid),
        .job         (job),
        .job_len     (job_len),
        .kb_idx      (kb_idx),
        .kb_char     (kb_char)
    );

    sktab_back #(
        .MAX_BUCKETS (MAX_BUCKETS),
        .MAX_ENTRIES (MAX_ENTRIES),
        .LEN_W       (LEN_W),
        .KI_W        (KI_W),
        .BKT_W       (BKT_W),
        .EI_W        (EI_W),
        .PTR_W       (PTR_W)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .bucket_count (bucket_count_reg),
        .job_valid    (job_valid),
        .job          (job),
        .job_len      (job_len),
        .job_take     (job_take),
        .back_busy    (back_busy),
        .kb_idx       (kb_idx),
        .kb_char      (kb_char),
        .result_valid (result_valid),
        .status       (status),
        .found_index  (found_index)
    );

endmodule
`default_nettype wire

FILE: rtl/core/sktab_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "string_key_hash_table_core_assert.svh"
module sktab_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        key_last,
    input wire logic        result_valid,
    input wire logic [2:0]  status,
    input wire logic [15:0] found_index
);
    import sktab_pkg::*;

    // status code is one of the defined ones
    `SKTAB_ASSERT_NOW(a_status_code, result_valid, status == ST_INSERTED || status == ST_FOUND || status == ST_MISSING || status == ST_POOL_FULL || status == ST_TOO_LONG)
    // index is zero unless found
    `SKTAB_ASSERT_NOW(a_index_zero, result_valid && status != ST_FOUND, found_index == 16'd0)
    // a mid-key beat causes no result
    `SKTAB_ASSERT_NEXT(a_no_mid_result, start && !busy && !key_last, !result_valid)
    // a taken key end raises busy
    `SKTAB_ASSERT_NEXT(a_busy_after_end, start && !busy && key_last, busy)

endmodule

bind string_key_hash_table_core sktab_checker u_chk (.*);
`default_nettype wire
